FILE: hw/rtl/gbf_pkg.sv
// Package: shared types and constants of the glob basename filter.
`timescale 1ns / 1ps
`default_nettype none
package gbf_pkg;

  // Special pattern and path characters
  localparam logic [7:0] CH_STAR     = 8'h2A;
  localparam logic [7:0] CH_QUESTION = 8'h3F;
  localparam logic [7:0] CH_SLASH    = 8'h2F;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LO     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_MID_LO = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_MID_HI = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_HI     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NAME_ON    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_FILT  = 3'd6;

  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned PAT_LEN_W  = 6;

  // Depth of the queue between front and back
  localparam int unsigned Q_DEPTH = 2;

  typedef enum logic [1:0] {
    TF_ANY   = 2'd0,
    TF_FILES = 2'd1,
    TF_DIRS  = 2'd2
  } tfilt_t;

  // Filter settings handed to the back end
  typedef struct packed {
    logic   name_filter_on;
    tfilt_t kind_sel;
  } gbf_filt_t;

  // Classification of one item, made by the front end
  typedef struct packed {
    logic adv;      // ordinary character: step the automaton
    logic restart;  // slash: restart at position zero
    logic last;     // final item of the path
    logic is_dir;   // entry kind
  } gbf_flags_t;

endpackage : gbf_pkg
`default_nettype wire

FILE: hw/rtl/gbf_ifs.sv
// Interfaces: input, result and configuration channels.
`timescale 1ns / 1ps
`default_nettype none
interface gbf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] path_char;
  logic       char_present;
  logic       is_last;
  logic       is_directory;

  modport source (output valid, path_char, char_present, is_last, is_directory,
                  input ready);
  modport sink   (input valid, path_char, char_present, is_last, is_directory,
                  output ready);
endinterface : gbf_in_if

interface gbf_out_if;
  logic valid;
  logic ready;
  logic selected;
  logic name_matched;
  logic type_matched;

  modport source (output valid, selected, name_matched, type_matched, input ready);
  modport sink   (input valid, selected, name_matched, type_matched, output ready);
endinterface : gbf_out_if

interface gbf_cfg_if;
  import gbf_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface : gbf_cfg_if
`default_nettype wire

FILE: hw/rtl/gbf_cfg.sv
// Configuration registers and pattern masks derived from them.
`timescale 1ns / 1ps
`default_nettype none
module gbf_cfg #(
  parameter int MAX_PATTERN = 32
) (
  input  wire                                clk,
  input  wire                                rst_n,
  gbf_cfg_if.sink                            cfg_chan,
  output logic [8*MAX_PATTERN-1:0]           pat_chars,
  output logic [MAX_PATTERN-1:0]             use_mask,
  output logic [MAX_PATTERN-1:0]             star_mask,
  output logic [MAX_PATTERN-1:0]             qmark_mask,
  output logic [$clog2(MAX_PATTERN+1)-1:0]   len_eff,
  output gbf_pkg::gbf_filt_t                 filt
);
  import gbf_pkg::*;

  localparam int LW = $clog2(MAX_PATTERN + 1);

  logic [7:0]    pat_r [MAX_PATTERN];
  logic [LW-1:0] len_r;
  gbf_filt_t     filt_r;
  logic          wr_en;

  assign cfg_chan.ready = 1'b1;
  assign wr_en = cfg_chan.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < MAX_PATTERN; b++) begin
        pat_r[b] <= 8'h00;
      end
      len_r  <= '0;
      filt_r <= '{name_filter_on: 1'b0, kind_sel: TF_ANY};
    end else if (wr_en) begin
      for (int b = 0; b < MAX_PATTERN; b++) begin
        if (cfg_chan.index == CFG_PAT_LO + CFG_IDX_W'(b >> 3)) begin
          pat_r[b] <= cfg_chan.data[(b & 7) * 8 +: 8];
        end
      end
      unique case (cfg_chan.index)
        CFG_PAT_LEN: begin
          // saturate at the pattern storage
          if (cfg_chan.data[PAT_LEN_W-1:0] > PAT_LEN_W'(MAX_PATTERN)) begin
            len_r <= LW'(MAX_PATTERN);
          end else begin
            len_r <= LW'(cfg_chan.data[PAT_LEN_W-1:0]);
          end
        end
        CFG_NAME_ON: begin
          filt_r.name_filter_on <= cfg_chan.data[0];
        end
        CFG_TYPE_FILT: begin
          filt_r.kind_sel <= tfilt_t'(cfg_chan.data[1:0]);
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      pat_chars[8*i +: 8] = pat_r[i];
      use_mask[i]         = LW'(i) < len_r;
      star_mask[i]        = use_mask[i] && (pat_r[i] == CH_STAR);
      qmark_mask[i]       = use_mask[i] && (pat_r[i] == CH_QUESTION);
    end
  end

  assign len_eff = len_r;
  assign filt    = filt_r;

endmodule : gbf_cfg
`default_nettype wire

FILE: hw/rtl/gbf_front.sv
// Front end: accepts path characters, classifies them and compares against the pattern.
`timescale 1ns / 1ps
`default_nettype none
module gbf_front #(
  parameter int MAX_PATTERN = 32
) (
  gbf_in_if.sink                   in_chan,
  input  wire [8*MAX_PATTERN-1:0]  pat_chars,
  input  wire [MAX_PATTERN-1:0]    use_mask,
  input  wire [MAX_PATTERN-1:0]    star_mask,
  input  wire [MAX_PATTERN-1:0]    qmark_mask,
  output logic                     push_valid,
  input  wire                      push_ready,
  output gbf_pkg::gbf_flags_t      push_flags,
  output logic [MAX_PATTERN-1:0]   push_match
);
  import gbf_pkg::*;

  logic is_slash;

  assign in_chan.ready = push_ready;
  assign push_valid    = in_chan.valid;

  assign is_slash = in_chan.path_char == CH_SLASH;

  always_comb begin
    push_flags.adv     = in_chan.char_present && !is_slash;
    push_flags.restart = in_chan.char_present && is_slash;
    push_flags.last    = in_chan.is_last;
    push_flags.is_dir  = in_chan.is_directory;
    // a position may step forward on '?' or an equal literal; '*' is handled in the back
    for (int i = 0; i < MAX_PATTERN; i++) begin
      push_match[i] = use_mask[i] && !star_mask[i] &&
                      (qmark_mask[i] || (pat_chars[8*i +: 8] == in_chan.path_char));
    end
  end

endmodule : gbf_front
`default_nettype wire

FILE: hw/rtl/gbf_queue.sv
// Queue: short FIFO between front end and back end.
`timescale 1ns / 1ps
`default_nettype none
module gbf_queue #(
  parameter int WIDTH = 36
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push_valid,
  output logic             push_ready,
  input  wire [WIDTH-1:0]  push_data,
  output logic             pop_valid,
  input  wire              pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  import gbf_pkg::*;

  localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CW = $clog2(Q_DEPTH + 1);

  logic [WIDTH-1:0] mem_r [Q_DEPTH];
  logic [PW-1:0]    wptr_r, wptr_nxt;
  logic [PW-1:0]    rptr_r, rptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             push, pop;

  assign push_ready = cnt_r != CW'(Q_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == PW'(Q_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PW'(Q_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

endmodule : gbf_queue
`default_nettype wire

FILE: hw/rtl/gbf_back.sv
// Back end: automaton state, star closure, result stage and output register.
`timescale 1ns / 1ps
`default_nettype none
module gbf_back #(
  parameter int MAX_PATTERN = 32
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               q_valid,
  output logic                              q_ready,
  input  gbf_pkg::gbf_flags_t               q_flags,
  input  wire [MAX_PATTERN-1:0]             q_match,
  input  wire [MAX_PATTERN-1:0]             star_mask,
  input  wire [$clog2(MAX_PATTERN+1)-1:0]   len_eff,
  input  gbf_pkg::gbf_filt_t                filt,
  gbf_out_if.source                         out_chan
);
  import gbf_pkg::*;

  localparam int SW = MAX_PATTERN + 1;
  localparam logic [SW-1:0] ONE_STATE = SW'(1);

  // Star closure as one carry chain: a star position propagates an active bit
  // to the next position. Carries of (star + (s & star)) are exactly that chain.
  function automatic logic [SW-1:0] closure(input logic [SW-1:0] s,
                                            input logic [MAX_PATTERN-1:0] star);
    logic [SW-1:0] a;
    logic [SW-1:0] b;
    logic [SW:0]   sum;
    a   = {1'b0, star};
    b   = s & a;
    sum = {1'b0, a} + {1'b0, b};
    return s | (sum[SW-1:0] ^ a ^ b);
  endfunction

  logic [SW-1:0]  state_r, state_nxt;
  logic [SW-1:0]  closed, stepped;
  logic           pop;

  logic           res_valid_r;
  logic [SW-1:0]  res_state_r;
  logic           res_dir_r;
  logic           res_adv, res_free, out_free;

  logic           out_valid_r;
  logic           sel_r, name_r, type_r;
  logic [SW-1:0]  res_closed;
  logic           name_ok, type_ok;

  // Step the automaton for the head of the queue
  assign closed = closure(state_r, star_mask);

  always_comb begin
    if (q_flags.restart) begin
      stepped = ONE_STATE;
    end else if (q_flags.adv) begin
      stepped = {1'b0, closed[MAX_PATTERN-1:0] & star_mask} |
                {closed[MAX_PATTERN-1:0] & q_match, 1'b0};
    end else begin
      stepped = state_r;
    end
  end

  assign out_free = !out_valid_r || out_chan.ready;
  assign res_adv  = res_valid_r && out_free;
  assign res_free = !res_valid_r || res_adv;
  assign q_ready  = !q_flags.last || res_free;
  assign pop      = q_valid && q_ready;

  always_comb begin
    state_nxt = state_r;
    if (pop) begin
      state_nxt = q_flags.last ? ONE_STATE : stepped;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ONE_STATE;
      res_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (pop && q_flags.last) begin
        res_valid_r <= 1'b1;
      end else if (res_adv) begin
        res_valid_r <= 1'b0;
      end
      if (res_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_flags.last) begin
      res_state_r <= stepped;
      res_dir_r   <= q_flags.is_dir;
    end
  end

  // Final closure and filter decision
  assign res_closed = closure(res_state_r, star_mask);
  assign name_ok    = !filt.name_filter_on || res_closed[len_eff];

  always_comb begin
    case (filt.kind_sel)
      TF_ANY:  type_ok = 1'b1;
      TF_DIRS: type_ok = res_dir_r;
      default: type_ok = !res_dir_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (res_adv) begin
      sel_r  <= name_ok && type_ok;
      name_r <= name_ok;
      type_r <= type_ok;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.selected     = sel_r;
  assign out_chan.name_matched = name_r;
  assign out_chan.type_matched = type_r;

  // restart at position zero after every path
  a_state_restart : assert property (@(posedge clk) disable iff (!rst_n)
    (pop && q_flags.last) |=> (state_r == ONE_STATE))
    else $error("state not restarted after last item");

  // a pending result waits while the output register is blocked
  a_res_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid_r && !out_free) |=> (res_valid_r && $stable(res_state_r)))
    else $error("result stage dropped while blocked");

  // a new result only comes from the result stage
  a_out_source : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(res_valid_r))
    else $error("output valid without a pending result");

endmodule : gbf_back
`default_nettype wire

FILE: hw/rtl/glob_basename_filter_unit.sv
// Top level: glob basename filter with decoupled front end and back end.
// Throughput: one path character per cycle while out_chan is ready; a last item stalls
//   while a result waits on a blocked output. A last item passes the queue register,
//   the automaton step into the result stage and the closure into the output register.
// The automaton step is one carry chain of MAX_PATTERN+1 bits and a mask; the byte
//   compares per position sit ahead of the queue.
// Reset (rst_n, synchronous): configuration to zero, queue emptied, automaton at position zero.
`timescale 1ns / 1ps
`default_nettype none
module glob_basename_filter_unit #(
  parameter int MAX_PATTERN = 32
) (
  input  wire        clk,
  input  wire        rst_n,
  gbf_cfg_if.sink    cfg_chan,
  gbf_in_if.sink     in_chan,
  gbf_out_if.source  out_chan
);
  import gbf_pkg::*;

  localparam int LW = $clog2(MAX_PATTERN + 1);
  localparam int QW = MAX_PATTERN + $bits(gbf_flags_t);

  // Pattern as configured, and per-position masks
  logic [8*MAX_PATTERN-1:0] pat_chars;
  logic [MAX_PATTERN-1:0]   use_mask;
  logic [MAX_PATTERN-1:0]   star_mask;
  logic [MAX_PATTERN-1:0]   qmark_mask;
  logic [LW-1:0]            len_eff;
  gbf_filt_t                filt;

  // Front end to queue
  logic                     push_valid, push_ready;
  gbf_flags_t               push_flags;
  logic [MAX_PATTERN-1:0]   push_match;

  // Queue to back end
  logic                     q_valid, q_ready;
  logic [QW-1:0]            q_data;
  gbf_flags_t               q_flags;
  logic [MAX_PATTERN-1:0]   q_match;

  gbf_cfg #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_chan   (cfg_chan),
    .pat_chars  (pat_chars),
    .use_mask   (use_mask),
    .star_mask  (star_mask),
    .qmark_mask (qmark_mask),
    .len_eff    (len_eff),
    .filt       (filt)
  );

  // Classify each character and compare it against every pattern position
  gbf_front #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_front (
    .in_chan    (in_chan),
    .pat_chars  (pat_chars),
    .use_mask   (use_mask),
    .star_mask  (star_mask),
    .qmark_mask (qmark_mask),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_flags (push_flags),
    .push_match (push_match)
  );

  // Decouple the two sides; a full queue holds off the input channel
  gbf_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_flags, push_match}),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  assign q_flags = gbf_flags_t'(q_data[QW-1:MAX_PATTERN]);
  assign q_match = q_data[MAX_PATTERN-1:0];

  // Advance the automaton, then close and filter on the last item of a path
  gbf_back #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_flags   (q_flags),
    .q_match   (q_match),
    .star_mask (star_mask),
    .len_eff   (len_eff),
    .filt      (filt),
    .out_chan  (out_chan)
  );

endmodule : glob_basename_filter_unit
`default_nettype wire

FILE: dv/testbench.sv
// Self-checking testbench for the glob basename filter unit.
`timescale 1ns / 1ps
module testbench;
  import gbf_pkg::*;

  localparam int PATTERN_MAX      = 32;
  localparam int SETTLE_CYCLES    = 6;
  localparam int LONG_HOLD_CYCLES = 200;
  localparam int PHASE_ITEMS      = 120;
  localparam int RANDOM_PHASES    = 13;
  localparam int QUIET_PHASES     = 2;    // closing phases run without any idling

  // Register index past the end of the map; a write to it must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  // Type filter code outside the enum; the block treats it as files only
  localparam logic [1:0] TF_UNDEFINED = 2'd3;
  localparam logic [7:0] CH_LETTER_A  = 8'h61;

  typedef logic [7:0] char_q_t[$];

  typedef struct packed {
    logic selected;
    logic name_matched;
    logic type_matched;
  } verdict_t;

  logic clk;
  logic rst_n;

  gbf_in_if  in_if ();
  gbf_out_if out_if ();
  gbf_cfg_if cfg_if ();

  glob_basename_filter_unit #(
    .MAX_PATTERN(PATTERN_MAX)
  ) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_chan(cfg_if),
    .in_chan (in_if),
    .out_chan(out_if)
  );

  // Shadow copy of the filter settings and of the matcher state
  logic [63:0] shadow_pattern [4];
  logic [5:0]  shadow_length;
  logic        shadow_name_on;
  logic [1:0]  shadow_type;
  logic [32:0] live_positions;     // bit i: first i pattern chars match, held without closure

  verdict_t pending_verdicts [$];  // verdicts owed by the block, oldest first

  int error_count;
  int items_sent;
  int ignored_items;
  int verdicts_checked;
  int settings_loaded;

  bit src_gaps_on;
  bit sink_gaps_on;
  bit noise_on;
  bit long_hold_pending;

  // ---------------------------------------------------------------------------
  // Clock and run limit
  // ---------------------------------------------------------------------------
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Kill a hung run; the slowest legal run is well under a tenth of this
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Matcher prediction
  // ---------------------------------------------------------------------------
  // Lengths above the pattern capacity saturate
  function automatic int unsigned live_length();
    return (shadow_length > PATTERN_MAX) ? PATTERN_MAX : int'(shadow_length);
  endfunction

  function automatic logic [7:0] pattern_byte(int unsigned k);
    return shadow_pattern[k / 8][(k % 8) * 8 +: 8];
  endfunction

  // Let every reachable star also match the empty run; ascending order chains stars
  function automatic logic [32:0] close_stars(logic [32:0] s);
    int unsigned n;
    int unsigned i;
    n = live_length();
    for (i = 0; i < n; i++) begin
      if (pattern_byte(i) == CH_STAR && s[i]) s[i + 1] = 1'b1;
    end
    return s;
  endfunction

  // Consume one ordinary path character
  function automatic logic [32:0] step_positions(logic [32:0] s, logic [7:0] c);
    logic [32:0] nxt;
    logic [7:0]  p;
    int unsigned n;
    int unsigned i;
    n   = live_length();
    nxt = '0;
    s   = close_stars(s);
    for (i = 0; i < n; i++) begin
      if (s[i]) begin
        p = pattern_byte(i);
        if (p == CH_STAR) nxt[i] = 1'b1;
        else if (p == CH_QUESTION || p == c) nxt[i + 1] = 1'b1;
      end
    end
    return nxt;
  endfunction

  // Advance the shadow state by one accepted transaction; queue a verdict on a last item
  function automatic void take_item(logic [7:0] c, logic present, logic last, logic dir);
    logic [32:0] closed;
    verdict_t    v;
    if (present) live_positions = (c == CH_SLASH) ? 33'd1 : step_positions(live_positions, c);
    if (last) begin
      closed = close_stars(live_positions);
      v.name_matched = shadow_name_on ? closed[live_length()] : 1'b1;
      if (shadow_type == TF_ANY) v.type_matched = 1'b1;
      else if (shadow_type == TF_DIRS) v.type_matched = dir;
      else v.type_matched = !dir;
      v.selected = v.name_matched & v.type_matched;
      pending_verdicts.push_back(v);
      live_positions = 33'd1;
    end
  endfunction

  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
    case (idx)
      CFG_PAT_LO:     shadow_pattern[0] = data;
      CFG_PAT_MID_LO: shadow_pattern[1] = data;
      CFG_PAT_MID_HI: shadow_pattern[2] = data;
      CFG_PAT_HI:     shadow_pattern[3] = data;
      CFG_PAT_LEN:    shadow_length     = data[PAT_LEN_W-1:0];
      CFG_NAME_ON:    shadow_name_on    = data[0];
      CFG_TYPE_FILT:  shadow_type       = data[1:0];
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: compare each accepted result with the oldest verdict
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    verdict_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_verdicts.size() == 0) begin
        error_count++;
        $error("result with no verdict pending: selected=%0b name=%0b type=%0b",
               out_if.selected, out_if.name_matched, out_if.type_matched);
      end else begin
        want = pending_verdicts.pop_front();
        verdicts_checked++;
        if (out_if.selected !== want.selected) begin
          error_count++;
          $error("selected: expected %0b, got %0b", want.selected, out_if.selected);
        end
        if (out_if.name_matched !== want.name_matched) begin
          error_count++;
          $error("name_matched: expected %0b, got %0b", want.name_matched, out_if.name_matched);
        end
        if (out_if.type_matched !== want.type_matched) begin
          error_count++;
          $error("type_matched: expected %0b, got %0b", want.type_matched, out_if.type_matched);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: random stall bursts, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_pending) begin
        // Hold off long enough for the block to fill and stall its input
        long_hold_pending = 1'b0;
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES - 1) @(posedge clk);
      end else if (sink_gaps_on && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(0, 8)) @(posedge clk);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Offer one path transaction; valid stays high afterwards so a following item
  // goes out back to back.
  task automatic send_item(logic [7:0] c, logic present, logic last, logic dir);
    if (src_gaps_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.path_char    <= c;
    in_if.char_present <= present;
    in_if.is_last      <= last;
    in_if.is_directory <= dir;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    take_item(c, present, last, dir);
    items_sent++;
  endtask

  // Send a whole path; either flag the last character or close with an end-only item
  task automatic send_path(char_q_t chars, logic dir, bit end_only);
    int n;
    int i;
    n = chars.size();
    for (i = 0; i < n; i++) begin
      if (noise_on && $urandom_range(0, 15) == 0) begin
        // Absent, non-last character: the block must skip it
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'($urandom_range(0, 1)));
        ignored_items++;
      end
      send_item(chars[i], 1'b1, (i == n - 1) && !end_only,
                (i == n - 1) ? dir : 1'($urandom_range(0, 1)));
    end
    if (end_only || n == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, dir);
  endtask

  function automatic char_q_t text_path(string s);
    char_q_t q;
    int i;
    q = {};
    for (i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  function automatic logic [255:0] pack_text(string p);
    logic [255:0] bits;
    int k;
    bits = '0;
    for (k = 0; k < p.len() && k < PATTERN_MAX; k++) bits[k * 8 +: 8] = p[k];
    return bits;
  endfunction

  // Drop valid, wait out every owed verdict, then let the pipeline go quiet
  task automatic quiesce();
    in_if.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write; valid is left high for a following write
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    apply_register(idx, data);
  endtask

  task automatic load_settings(logic [255:0] bytes, logic [63:0] len_word,
                               logic [63:0] name_word, logic [63:0] type_word);
    quiesce();
    cfg_write(CFG_PAT_LO,     bytes[63:0]);
    cfg_write(CFG_PAT_MID_LO, bytes[127:64]);
    cfg_write(CFG_PAT_MID_HI, bytes[191:128]);
    cfg_write(CFG_PAT_HI,     bytes[255:192]);
    cfg_write(CFG_PAT_LEN,    len_word);
    cfg_write(CFG_NAME_ON,    name_word);
    cfg_write(CFG_TYPE_FILT,  type_word);
    cfg_if.valid <= 1'b0;
    settings_loaded++;
  endtask

  task automatic load_text_pattern(string p, logic name_on, logic [1:0] tf);
    load_settings(pack_text(p), 64'(p.len()), {63'd0, name_on}, {62'd0, tf});
  endtask

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------
  // Out of reset: name filter off and any type, so every entry is selected
  task automatic test_reset_state();
    send_path(text_path("a"), 1'b1, 1'b0);
  endtask

  task automatic test_wildcards();
    load_text_pattern("a?*", 1'b1, TF_ANY);
    send_path(text_path("ab"), 1'b0, 1'b0);   // star takes the empty run
    send_path(text_path("x/a"), 1'b0, 1'b0);  // question mark left unmatched
    send_path(text_path("a/"), 1'b0, 1'b0);   // trailing slash empties the basename
  endtask

  // Empty basename matches an all-star pattern, both after a slash and for an empty path
  task automatic test_empty_basename();
    load_text_pattern("**", 1'b1, TF_ANY);
    send_path(text_path("d/"), 1'b1, 1'b0);
    send_path(text_path(""), 1'b0, 1'b1);
  endtask

  // Zero and all-ones bytes are plain literals on both sides
  task automatic test_zero_bytes();
    logic [255:0] bytes;
    char_q_t      q;
    bytes = '0;
    bytes[15:8] = 8'hFF;
    load_settings(bytes, 64'd2, 64'd1, {62'd0, TF_ANY});
    q = {8'h00, 8'hFF};
    send_path(q, 1'b0, 1'b0);
  endtask

  task automatic test_empty_pattern();
    load_text_pattern("", 1'b1, TF_ANY);
    send_path(text_path("q"), 1'b0, 1'b0);
    send_path(text_path(""), 1'b0, 1'b1);
  endtask

  // Length 63 must clamp to the capacity; all stars then accept anything
  task automatic test_saturated_length();
    logic [255:0] bytes;
    int k;
    for (k = 0; k < PATTERN_MAX; k++) bytes[k * 8 +: 8] = CH_STAR;
    load_settings(bytes, 64'd63, 64'd1, {62'd0, TF_ANY});
    send_path(text_path("z"), 1'b0, 1'b0);
  endtask

  task automatic test_type_filter();
    load_text_pattern("", 1'b0, TF_FILES);
    send_path(text_path("f"), 1'b1, 1'b0);
    load_text_pattern("", 1'b0, TF_DIRS);
    send_path(text_path("f"), 1'b1, 1'b0);
    send_path(text_path("f"), 1'b0, 1'b0);
    load_text_pattern("", 1'b0, TF_UNDEFINED);
    send_path(text_path("f"), 1'b1, 1'b0);
  endtask

  // Change the pattern between two characters of one path; the held state stays as it is
  task automatic test_midpath_config();
    logic [255:0] bytes;
    load_text_pattern("ab", 1'b1, TF_ANY);
    send_item(CH_LETTER_A, 1'b1, 1'b0, 1'b0);
    quiesce();
    bytes = pack_text("?b");
    cfg_write(CFG_PAT_LO, bytes[63:0]);
    cfg_if.valid <= 1'b0;
    send_item(CH_LETTER_A + 8'd1, 1'b1, 1'b1, 1'b0);
  endtask

  task automatic test_unused_index();
    quiesce();
    cfg_write(CFG_UNUSED, {$urandom, $urandom});
    cfg_if.valid <= 1'b0;
    send_path(text_path("b"), 1'b0, 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // Random stimulus
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return CH_LETTER_A + 8'($urandom_range(0, 2));
      6:                return CH_SLASH;
      7:                return CH_STAR;
      default:          return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_pattern_byte();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return CH_LETTER_A + 8'($urandom_range(0, 2));
      4, 5:       return CH_STAR;
      6, 7:       return CH_QUESTION;
      default:    return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly a path whose basename is built to fit the pattern, sometimes with a
  // corrupted character, sometimes plain noise or a trailing slash.
  function automatic char_q_t make_path();
    char_q_t     q;
    logic [7:0]  p;
    logic [7:0]  v;
    int unsigned k;
    q = {};
    repeat ($urandom_range(0, 2)) begin
      repeat ($urandom_range(1, 3)) q.push_back(CH_LETTER_A + 8'($urandom_range(0, 2)));
      q.push_back(CH_SLASH);
    end
    if ($urandom_range(0, 3) != 0) begin
      for (k = 0; k < live_length(); k++) begin
        p = pattern_byte(k);
        if (p == CH_STAR) begin
          repeat ($urandom_range(0, 3)) q.push_back(pick_char());
        end else if (p == CH_QUESTION) begin
          v = 8'($urandom_range(0, 255));
          q.push_back((v == CH_SLASH) ? CH_LETTER_A : v);
        end else begin
          q.push_back(p);
        end
      end
      if ($urandom_range(0, 4) == 0 && q.size() > 0) q[$urandom_range(0, q.size() - 1)] = pick_char();
    end else begin
      repeat ($urandom_range(0, 6)) q.push_back(pick_char());
    end
    if ($urandom_range(0, 15) == 0) q.push_back(CH_SLASH);
    return q;
  endfunction

  task automatic run_random_phase(int ph);
    logic [255:0] bytes;
    logic [63:0]  len_word;
    logic [63:0]  name_word;
    logic [63:0]  type_word;
    char_q_t      path;
    bit           end_only;
    int           sent;
    int           k;
    for (k = 0; k < PATTERN_MAX; k++) bytes[k * 8 +: 8] = pick_pattern_byte();
    // Upper bits of the narrow registers carry junk that must be dropped
    len_word  = {$urandom, $urandom};
    name_word = {$urandom, $urandom};
    type_word = {$urandom, $urandom};
    case (ph)
      0: len_word[5:0] = 6'd32;
      1: len_word[5:0] = 6'd0;
      2: len_word[5:0] = 6'($urandom_range(33, 63));
      6: begin
        for (k = 0; k < PATTERN_MAX; k++) bytes[k * 8 +: 8] = CH_QUESTION;
        len_word[5:0] = 6'd32;
      end
      default: begin
        case ($urandom_range(0, 9))
          7, 8:    len_word[5:0] = 6'($urandom_range(9, 32));
          9:       len_word[5:0] = 6'($urandom_range(33, 63));
          default: len_word[5:0] = 6'($urandom_range(0, 8));
        endcase
      end
    endcase
    name_word[0]   = (ph == 5) ? 1'b0 : ($urandom_range(0, 3) != 0);
    type_word[1:0] = 2'($urandom_range(0, 3));
    load_settings(bytes, len_word, name_word, type_word);

    // Stall results for a long stretch while paths keep coming
    if (ph == 3) long_hold_pending = 1'b1;

    sent = 0;
    while (sent < PHASE_ITEMS) begin
      path     = make_path();
      end_only = ($urandom_range(0, 7) == 0);
      send_path(path, 1'($urandom_range(0, 1)), end_only);
      sent += path.size() + ((end_only || path.size() == 0) ? 1 : 0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    in_if.valid        <= 1'b0;
    in_if.path_char    <= '0;
    in_if.char_present <= 1'b0;
    in_if.is_last      <= 1'b0;
    in_if.is_directory <= 1'b0;
    cfg_if.valid       <= 1'b0;
    cfg_if.index       <= '0;
    cfg_if.data        <= '0;
    rst_n              <= 1'b0;
    error_count       = 0;
    items_sent        = 0;
    ignored_items     = 0;
    verdicts_checked  = 0;
    settings_loaded   = 0;
    src_gaps_on       = 1'b0;
    sink_gaps_on      = 1'b0;
    noise_on          = 1'b0;
    long_hold_pending = 1'b0;
    shadow_pattern[0] = '0;
    shadow_pattern[1] = '0;
    shadow_pattern[2] = '0;
    shadow_pattern[3] = '0;
    shadow_length     = '0;
    shadow_name_on    = 1'b0;
    shadow_type       = TF_ANY;
    live_positions    = 33'd1;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    src_gaps_on  = 1'b1;
    sink_gaps_on = 1'b1;
    test_reset_state();
    test_wildcards();
    test_empty_basename();
    test_zero_bytes();
    test_empty_pattern();
    test_saturated_length();
    test_type_filter();
    test_midpath_config();
    test_unused_index();

    noise_on = 1'b1;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      // Run the closing phases at full rate on both sides
      if (ph >= RANDOM_PHASES - QUIET_PHASES) begin
        src_gaps_on  = 1'b0;
        sink_gaps_on = 1'b0;
      end
      run_random_phase(ph);
    end

    quiesce();
    $display("Covered %0d path transactions (%0d skipped) and %0d verdicts over %0d settings,",
             items_sent, ignored_items, verdicts_checked, settings_loaded);
    $display("with idle bursts on both sides, a long result hold-off and a mid-path change.");
    if (error_count == 0 && pending_verdicts.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule : testbench

FILE: glob_basename_filter_unit.f
hw/rtl/gbf_pkg.sv
hw/rtl/gbf_ifs.sv
hw/rtl/gbf_cfg.sv
hw/rtl/gbf_front.sv
hw/rtl/gbf_queue.sv
hw/rtl/gbf_back.sv
hw/rtl/glob_basename_filter_unit.sv
dv/testbench.sv
